>>> rtl/core/sfef_pkg.sv
// Shared constants, transaction types and command/status bundles of the spanning forest filter.
package sfef_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int VTX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int END_W = 8;
   localparam int CFG_W = 9;
   localparam int LEFT_W = 9;
   localparam int CMP_W = CFG_W + CNT_W + END_W;

   localparam logic [CFG_W-1:0] NUM_VERTICES_RESET = CFG_W'(256);

   typedef struct packed {
      logic             first_edge;
      logic [END_W-1:0] end_u;
      logic [END_W-1:0] end_v;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic              out_of_range;
      logic              tree_complete;
      logic [LEFT_W-1:0] components_left;
   } rsp_type;

   typedef enum logic [1:0] {
      RD_U    = 2'd0,
      RD_V    = 2'd1,
      RD_SCAN = 2'd2
   } rd_src_type;

   typedef struct packed {
      logic       accept;
      logic       rd_en;
      rd_src_type rd_src;
      logic       cap_lu;
      logic       cap_lv;
      logic       scan_clr;
      logic       scan_inc;
      logic       dec_count;
      logic       rsp_load;
      logic       accepted;
   } cmd_type;

   typedef struct packed {
      logic oor;
      logic count_gt1;
      logic labels_differ;
      logic scan_last;
      logic rsp_busy;
   } status_type;

   function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] cfg);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(cfg);
      if (wide == CMP_W'(0)) begin
         return CNT_W'(1);
      end else if (wide > CMP_W'(MAX_VERTICES)) begin
         return CNT_W'(MAX_VERTICES);
      end else begin
         return CNT_W'(cfg);
      end
   endfunction

endpackage

>>> rtl/core/spanning_forest_edge_filter_core.sv
// Top level of the spanning forest edge filter: controller and datapath.
//
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_stall  sfef_pkg::req_type (first_edge, end_u, end_v)
//  rsp      out        rsp_valid/rsp_stall  sfef_pkg::rsp_type (accepted, out_of_range,
//                                           tree_complete, components_left)
//  csr      in         csr_valid/csr_ready  num_vertices, 9 bits
//
// An out-of-range edge or one after the tree is complete goes from the check straight to the
// result, an edge inside one component also reads and compares both labels, and an accepted
// edge adds a relabel scan over the n active vertices, reading one label memory entry per cycle.
// Reset and a first edge clear all label valid bits at once, so no clearing pass is needed.
// A new edge is taken while the previous result waits in the output register; a stalled
// result holds the block in its final step until that transaction completes.
module spanning_forest_edge_filter_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sfef_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sfef_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfef_pkg::CFG_W-1:0]    csr_data
);

   sfef_pkg::cmd_type    cmd;
   sfef_pkg::status_type status;

   assign csr_ready = 1'b1;

   sfef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sfef_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

>>> rtl/core/sfef_ctrl.sv
// Controller state machine that sequences lookup, relabel scan and result hand-off.
module sfef_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sfef_pkg::status_type   status,
   output sfef_pkg::cmd_type      cmd
);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_CHECK   = 8'b0000_0010,
      ST_LOAD_U  = 8'b0000_0100,
      ST_LOAD_V  = 8'b0000_1000,
      ST_COMPARE = 8'b0001_0000,
      ST_SCAN    = 8'b0010_0000,
      ST_DRAIN   = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      acc_ff;
   logic      acc_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      cmd      = '0;
      cmd.rd_src   = sfef_pkg::RD_U;
      cmd.accepted = acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               acc_in     = 1'b0;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.oor || !status.count_gt1) begin
               state_in = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_src = sfef_pkg::RD_U;
               state_in   = ST_LOAD_U;
            end
         end
         ST_LOAD_U: begin
            cmd.cap_lu = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_src = sfef_pkg::RD_V;
            state_in   = ST_LOAD_V;
         end
         ST_LOAD_V: begin
            cmd.cap_lv = 1'b1;
            state_in   = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (status.labels_differ) begin
               cmd.scan_clr = 1'b1;
               state_in     = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_src   = sfef_pkg::RD_SCAN;
            cmd.scan_inc = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.dec_count = 1'b1;
            acc_in        = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         acc_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

>>> rtl/core/sfef_datapath.sv
// Datapath with the label memory, its valid bits, the component count and the result register.
module sfef_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  sfef_pkg::req_type             req_data,
   output sfef_pkg::rsp_type             rsp_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          csr_write,
   input  logic [sfef_pkg::CFG_W-1:0]    csr_data,
   input  sfef_pkg::cmd_type             cmd,
   output sfef_pkg::status_type          status
);

   logic [sfef_pkg::VTX_W-1:0]  label_mem [sfef_pkg::MAX_VERTICES];
   logic                        label_vld_ff [sfef_pkg::MAX_VERTICES];

   logic [sfef_pkg::CFG_W-1:0]  num_vertices_ff;
   logic [sfef_pkg::CFG_W-1:0]  num_vertices_in;
   logic [sfef_pkg::CNT_W-1:0]  count_ff;
   logic [sfef_pkg::CNT_W-1:0]  count_in;
   logic [sfef_pkg::END_W-1:0]  u_ff;
   logic [sfef_pkg::END_W-1:0]  u_in;
   logic [sfef_pkg::END_W-1:0]  v_ff;
   logic [sfef_pkg::END_W-1:0]  v_in;
   logic [sfef_pkg::VTX_W-1:0]  lu_ff;
   logic [sfef_pkg::VTX_W-1:0]  lu_in;
   logic [sfef_pkg::VTX_W-1:0]  lv_ff;
   logic [sfef_pkg::VTX_W-1:0]  lv_in;
   logic [sfef_pkg::VTX_W-1:0]  scan_idx_ff;
   logic [sfef_pkg::VTX_W-1:0]  scan_idx_in;
   logic                        scan_pend_ff;
   logic                        scan_pend_in;
   logic [sfef_pkg::VTX_W-1:0]  rd_data_ff;
   logic                        rd_vld_ff;
   logic [sfef_pkg::VTX_W-1:0]  rd_idx_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   sfef_pkg::rsp_type           rsp_data_ff;
   sfef_pkg::rsp_type           rsp_data_in;

   logic [sfef_pkg::CNT_W-1:0]  eff_n;
   logic [sfef_pkg::VTX_W-1:0]  rd_addr;
   logic [sfef_pkg::VTX_W-1:0]  label_rd;
   logic                        wr_en;
   logic                        oor;
   logic                        clear_labels;

   assign eff_n        = sfef_pkg::eff_count(num_vertices_ff);
   assign oor          = (sfef_pkg::CMP_W'(u_ff) >= sfef_pkg::CMP_W'(eff_n))
                      || (sfef_pkg::CMP_W'(v_ff) >= sfef_pkg::CMP_W'(eff_n));
   assign label_rd     = rd_vld_ff ? rd_data_ff : rd_idx_ff;
   assign wr_en        = scan_pend_ff && (label_rd == lv_ff);
   assign clear_labels = cmd.accept && req_data.first_edge;

   always_comb begin
      unique case (cmd.rd_src)
         sfef_pkg::RD_U:    rd_addr = sfef_pkg::VTX_W'(u_ff);
         sfef_pkg::RD_V:    rd_addr = sfef_pkg::VTX_W'(v_ff);
         sfef_pkg::RD_SCAN: rd_addr = scan_idx_ff;
         default:           rd_addr = scan_idx_ff;
      endcase
   end

   always_comb begin
      num_vertices_in = csr_write ? csr_data : num_vertices_ff;
      u_in  = cmd.accept ? req_data.end_u : u_ff;
      v_in  = cmd.accept ? req_data.end_v : v_ff;
      lu_in = cmd.cap_lu ? label_rd : lu_ff;
      lv_in = cmd.cap_lv ? label_rd : lv_ff;

      count_in = count_ff;
      if (clear_labels) begin
         count_in = eff_n;
      end else if (cmd.dec_count) begin
         count_in = count_ff - sfef_pkg::CNT_W'(1);
      end

      scan_idx_in = scan_idx_ff;
      if (cmd.scan_clr) begin
         scan_idx_in = '0;
      end else if (cmd.scan_inc) begin
         scan_idx_in = scan_idx_ff + sfef_pkg::VTX_W'(1);
      end
      scan_pend_in = cmd.rd_en && (cmd.rd_src == sfef_pkg::RD_SCAN);

      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.rsp_load) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.accepted        = cmd.accepted;
         rsp_data_in.out_of_range    = oor;
         rsp_data_in.tree_complete   = (count_ff == sfef_pkg::CNT_W'(1));
         rsp_data_in.components_left = sfef_pkg::LEFT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= label_mem[rd_addr];
      end
      if (wr_en) begin
         label_mem[rd_idx_ff] <= lu_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_labels) begin
         for (int i = 0; i < sfef_pkg::MAX_VERTICES; i++) begin
            label_vld_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         label_vld_ff[rd_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_vld_ff <= label_vld_ff[rd_addr];
         rd_idx_ff <= rd_addr;
      end
      u_ff        <= u_in;
      v_ff        <= v_in;
      lu_ff       <= lu_in;
      lv_ff       <= lv_in;
      scan_idx_ff <= scan_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vertices_ff <= sfef_pkg::NUM_VERTICES_RESET;
         count_ff        <= sfef_pkg::eff_count(sfef_pkg::NUM_VERTICES_RESET);
         scan_pend_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         num_vertices_ff <= num_vertices_in;
         count_ff        <= count_in;
         scan_pend_ff    <= scan_pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.oor           = oor;
   assign status.count_gt1     = (count_ff > sfef_pkg::CNT_W'(1));
   assign status.labels_differ = (lu_ff != lv_ff);
   assign status.scan_last     = (scan_idx_ff == sfef_pkg::VTX_W'(eff_n - sfef_pkg::CNT_W'(1)));
   assign status.rsp_busy      = rsp_valid_ff && rsp_stall;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("Result register overwritten while a transaction is pending.");

   a_dec_above_one: assert property (@(posedge clock) disable iff (reset)
      cmd.dec_count |-> (count_ff > sfef_pkg::CNT_W'(1)))
      else $error("Component count decremented at or below one.");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (sfef_pkg::CMP_W'(rd_idx_ff) < sfef_pkg::CMP_W'(eff_n)))
      else $error("Relabel write outside the active vertex range.");

   a_accept_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load && cmd.accepted |-> !oor)
      else $error("Edge accepted although an endpoint is out of range.");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the spanning forest edge filter core, with an edge scoreboard.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 9;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_PHASES = 12;
   localparam int EDGES_PER_PHASE = 70;

   class forest_scoreboard;
      logic [sfef_pkg::VTX_W-1:0] label [sfef_pkg::MAX_VERTICES];
      logic [sfef_pkg::CNT_W-1:0] comp_count;
      logic [sfef_pkg::CFG_W-1:0] vertex_cfg;
      sfef_pkg::rsp_type expected_verdicts[$];
      int edges_taken;
      int verdicts_checked;
      int merges;
      int oor_hits;
      int completions;
      int mismatches;

      function new();
         vertex_cfg = sfef_pkg::NUM_VERTICES_RESET;
         restart_graph();
      endfunction

      function int active_vertices();
         if (vertex_cfg == 0) begin
            return 1;
         end
         if (int'(vertex_cfg) > sfef_pkg::MAX_VERTICES) begin
            return sfef_pkg::MAX_VERTICES;
         end
         return int'(vertex_cfg);
      endfunction

      function void restart_graph();
         int i;
         for (i = 0; i < sfef_pkg::MAX_VERTICES; i++) begin
            label[i] = sfef_pkg::VTX_W'(i);
         end
         comp_count = sfef_pkg::CNT_W'(active_vertices());
      endfunction

      function void write_vertices(input logic [sfef_pkg::CFG_W-1:0] value);
         vertex_cfg = value;
      endfunction

      function void take_edge(input sfef_pkg::req_type e);
         sfef_pkg::rsp_type verdict;
         logic [sfef_pkg::VTX_W-1:0] lu;
         logic [sfef_pkg::VTX_W-1:0] lv;
         int n;
         int i;
         if (e.first_edge) begin
            restart_graph();
         end
         n = active_vertices();
         verdict = '0;
         verdict.out_of_range = (int'(e.end_u) >= n) || (int'(e.end_v) >= n);
         if (!verdict.out_of_range && comp_count > 1) begin
            lu = label[e.end_u];
            lv = label[e.end_v];
            if (lu != lv) begin
               for (i = 0; i < n; i++) begin
                  if (label[i] == lv) begin
                     label[i] = lu;
                  end
               end
               comp_count = comp_count - sfef_pkg::CNT_W'(1);
               verdict.accepted = 1'b1;
               merges++;
            end
         end
         verdict.tree_complete = (comp_count == 1);
         verdict.components_left = sfef_pkg::LEFT_W'(comp_count);
         if (verdict.out_of_range) begin
            oor_hits++;
         end
         if (verdict.tree_complete) begin
            completions++;
         end
         expected_verdicts.insert(expected_verdicts.size(), verdict);
         edges_taken++;
      endfunction

      function void check_verdict(input sfef_pkg::rsp_type got);
         sfef_pkg::rsp_type want;
         verdicts_checked++;
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Result %0d arrived with no edge outstanding:", verdicts_checked);
               $display("   acc=%0d oor=%0d done=%0d left=%0d",
                        got.accepted, got.out_of_range, got.tree_complete,
                        got.components_left);
            end
            return;
         end
         want = expected_verdicts.pop_front();
         if (got.accepted !== want.accepted || got.out_of_range !== want.out_of_range ||
             got.tree_complete !== want.tree_complete ||
             got.components_left !== want.components_left) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Result %0d mismatch:", verdicts_checked);
               $display("   expected acc=%0d oor=%0d done=%0d left=%0d",
                        want.accepted, want.out_of_range, want.tree_complete,
                        want.components_left);
               $display("   got      acc=%0d oor=%0d done=%0d left=%0d",
                        got.accepted, got.out_of_range, got.tree_complete,
                        got.components_left);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   sfef_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   sfef_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sfef_pkg::CFG_W-1:0] csr_data = '0;
   logic hold_off = 1'b0;

   forest_scoreboard forest_check = new();
   sfef_pkg::req_type edge_queue[$];
   int edges_queued = 0;
   int cfg_writes = 0;
   int burst_left = 0;
   int gap_left = 0;
   logic [15:0] stall_pattern = '0;
   int pattern_age = 0;
   int quiet_cycles = 0;

   spanning_forest_edge_filter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A new edge is offered as soon as the previous one has been taken, with random gaps between bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            forest_check.take_edge(req_data);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (edge_queue.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= edge_queue.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = 16'h0000;
               1: stall_pattern = 16'h8421;
               default: stall_pattern = 16'($urandom);
            endcase
            pattern_age = $urandom_range(20, 120);
         end else begin
            pattern_age--;
         end
         stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
         rsp_stall <= hold_off || stall_pattern[0];
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         forest_check.check_verdict(rsp_data);
      end
   end

   // The receiver holds off once while plenty of edges are still waiting to go in.
   initial begin
      while (!(forest_check.edges_taken >= 300 && edge_queue.size() > 20)) begin
         @(posedge clock);
      end
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function void queue_edge(input int first, input int u, input int v);
      sfef_pkg::req_type e;
      e.first_edge = 1'(first);
      e.end_u = sfef_pkg::END_W'(u);
      e.end_v = sfef_pkg::END_W'(v);
      edge_queue.insert(edge_queue.size(), e);
      edges_queued++;
   endfunction

   task automatic wait_for_idle();
      while (forest_check.edges_taken != edges_queued ||
             forest_check.expected_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_vertex_count(input int value);
      wait_for_idle();
      csr_valid <= 1'b1;
      csr_data <= sfef_pkg::CFG_W'(value);
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      forest_check.write_vertices(sfef_pkg::CFG_W'(value));
      cfg_writes++;
   endtask

   initial begin
      int phase;
      int n;
      int left;
      int span;
      int pick;
      int k;
      int u;
      int v;
      bit fresh;
      int size;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      queue_edge(0, 0, 255);
      queue_edge(0, 255, 0);
      queue_edge(0, 7, 7);
      queue_edge(0, 128, 127);
      queue_edge(1, 255, 255);
      queue_edge(0, 0, 1);
      set_vertex_count(0);
      queue_edge(0, 0, 0);
      queue_edge(0, 1, 0);
      queue_edge(1, 0, 0);
      queue_edge(0, 255, 0);
      set_vertex_count(2);
      queue_edge(0, 0, 1);
      queue_edge(1, 0, 1);
      queue_edge(0, 1, 0);
      queue_edge(0, 0, 2);
      set_vertex_count(511);
      queue_edge(1, 200, 100);
      queue_edge(0, 255, 128);
      queue_edge(0, 100, 255);
      queue_edge(0, 128, 200);
      set_vertex_count(1);
      queue_edge(1, 0, 0);
      set_vertex_count(3);
      queue_edge(1, 2, 0);
      queue_edge(0, 1, 2);
      queue_edge(0, 0, 1);
      queue_edge(0, 3, 0);
      set_vertex_count(300);
      queue_edge(0, 254, 255);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0: size = $urandom_range(0, 1);
            1: size = $urandom_range(256, 511);
            2: size = $urandom_range(100, 256);
            default: size = $urandom_range(2, 20);
         endcase
         set_vertex_count(size);
         n = forest_check.active_vertices();
         left = EDGES_PER_PHASE;
         fresh = ($urandom_range(0, 4) != 0);
         while (left > 0) begin
            span = $urandom_range(1, 2 * n + 2);
            for (k = 0; k < span && left > 0; k++) begin
               pick = $urandom_range(0, 19);
               u = $urandom_range(0, n - 1);
               v = $urandom_range(0, n - 1);
               if (pick == 0) begin
                  queue_edge($urandom_range(0, 1), $urandom_range(0, 255),
                             $urandom_range(0, 255));
               end else if (pick == 1 && n < sfef_pkg::MAX_VERTICES) begin
                  if ($urandom_range(0, 1) == 0) begin
                     u = $urandom_range(n, 255);
                  end else begin
                     v = $urandom_range(n, 255);
                  end
                  queue_edge(0, u, v);
               end else begin
                  queue_edge(int'(k == 0 && fresh), u, v);
               end
               left--;
            end
            fresh = 1'b1;
         end
      end

      wait_for_idle();
      $display("Covered %0d edges across %0d vertex count writes: %0d merges, %0d out of range.",
               forest_check.edges_taken, cfg_writes, forest_check.merges, forest_check.oor_hits);
      $display("Checked %0d results, %0d with one component left; %0d mismatches, %0d missing.",
               forest_check.verdicts_checked, forest_check.completions, forest_check.mismatches,
               forest_check.expected_verdicts.size());
      if (forest_check.mismatches == 0 && forest_check.expected_verdicts.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/sfef_pkg.sv
rtl/core/sfef_ctrl.sv
rtl/core/sfef_datapath.sv
rtl/core/spanning_forest_edge_filter_core.sv
tb/sv/tb_top.sv
